// ----- rtl/iig_pkg.sv -----
// Package for the integral image generator: sizes, configuration register
// indexes and the item record passed from the scan stage to the accumulator.
// No dependencies.
package iig_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int PIX_W  = 8;
  localparam int VAL_W  = 2 * PIX_W;
  localparam int CSUM_W = 27;
  localparam int ACC_W  = 37;
  localparam int SUM_W  = 36;
  localparam int CFG_W  = 11;
  localparam int CFG_IDX_W = 2;

  localparam int OUT_TDATA_W = ((SUM_W + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_MODE  = 2'd2;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             row_zero;
    logic             last_col;
    logic             last_row;
    logic [VAL_W-1:0] value;
  } item_t;

endpackage

// ----- rtl/integral_image_generator.sv -----
// Integral image generator top level: configuration registers, memory clear
// after reset, and the scan, column memory and accumulator stages.
// Depends on iig_pkg, iig_col_ram, iig_scan and iig_accum.

// Takes one 8-bit pixel per clock in raster order and returns the sum of all
// pixels of the frame above and to the left of it, inclusive (or of their
// squares when square_mode is set), via the accumulator's item and result
// registers. The rate is one pixel per clock while the output is not stalled,
// set by one read-modify-write of the column sum memory per pixel; a pixel in
// the same column as the one before takes its column sum by forwarding. After
// reset the block clears all MAX_WIDTH (1024) column memory entries with
// in_tready low; configuration writes are taken during that time. Width and
// height of zero act as one, values above the maximum act as the maximum.
// out_tlast marks a row's last pixel and out_tuser the frame's last pixel.
module integral_image_generator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [iig_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [iig_pkg::CFG_W-1:0]            cfg_wdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [iig_pkg::PIX_W-1:0]            in_tdata,   // [7:0] pixel
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [iig_pkg::OUT_TDATA_W-1:0]      out_tdata,  // [35:0] area_sum, rest zero
  output logic                                 out_tlast,  // row_end
  output logic [0:0]                           out_tuser   // [0] frame_end
);

  logic [iig_pkg::CFG_W-1:0]  width_r;
  logic [iig_pkg::CFG_W-1:0]  height_r;
  logic                       square_r;
  logic [iig_pkg::COL_W:0]    width_eff;
  logic [iig_pkg::ROW_W:0]    height_eff;

  logic                       clearing_r, clearing_nxt;
  logic [iig_pkg::COL_W-1:0]  clr_addr_r, clr_addr_nxt;

  logic                       in_fire;
  logic                       acc_ready;
  iig_pkg::item_t             item;

  logic                       st_wr_en;
  logic [iig_pkg::COL_W-1:0]  st_wr_addr;
  logic [iig_pkg::CSUM_W-1:0] st_wr_data;
  logic                       ram_wr_en;
  logic [iig_pkg::COL_W-1:0]  ram_wr_addr;
  logic [iig_pkg::CSUM_W-1:0] ram_wr_data;
  logic [iig_pkg::CSUM_W-1:0] ram_rd_data;

  logic [iig_pkg::SUM_W-1:0]  sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= iig_pkg::CFG_W'(1024);
      height_r <= iig_pkg::CFG_W'(1024);
      square_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        iig_pkg::CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
        iig_pkg::CFG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        iig_pkg::CFG_SQUARE_MODE:  square_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r == '0) begin
      width_eff = (iig_pkg::COL_W+1)'(1);
    end else if (int'(width_r) > iig_pkg::MAX_WIDTH) begin
      width_eff = (iig_pkg::COL_W+1)'(iig_pkg::MAX_WIDTH);
    end else begin
      width_eff = (iig_pkg::COL_W+1)'(width_r);
    end
    if (height_r == '0) begin
      height_eff = (iig_pkg::ROW_W+1)'(1);
    end else if (int'(height_r) > iig_pkg::MAX_HEIGHT) begin
      height_eff = (iig_pkg::ROW_W+1)'(iig_pkg::MAX_HEIGHT);
    end else begin
      height_eff = (iig_pkg::ROW_W+1)'(height_r);
    end
  end

  // Clearing pass: one column entry per cycle after reset.
  always_comb begin
    clearing_nxt = clearing_r;
    clr_addr_nxt = clr_addr_r;
    if (clearing_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == iig_pkg::COL_W'(iig_pkg::MAX_WIDTH - 1)) begin
        clearing_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  assign in_tready = !clearing_r && acc_ready;
  assign in_fire   = in_tvalid && in_tready;

  iig_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (in_fire),
    .pixel      (in_tdata),
    .square     (square_r),
    .width_eff  (width_eff),
    .height_eff (height_eff),
    .item       (item)
  );

  assign ram_wr_en   = clearing_r || st_wr_en;
  assign ram_wr_addr = clearing_r ? clr_addr_r : st_wr_addr;
  assign ram_wr_data = clearing_r ? '0 : st_wr_data;

  iig_col_ram u_col_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (in_fire),
    .rd_addr (item.col),
    .rd_data (ram_rd_data)
  );

  iig_accum u_accum (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (in_fire),
    .item_in       (item),
    .rd_data       (ram_rd_data),
    .ready         (acc_ready),
    .wr_en         (st_wr_en),
    .wr_addr       (st_wr_addr),
    .wr_data       (st_wr_data),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_sum       (sum),
    .out_row_end   (out_tlast),
    .out_frame_end (out_tuser[0])
  );

  assign out_tdata = iig_pkg::OUT_TDATA_W'(sum);

endmodule

// ----- rtl/iig_col_ram.sv -----
// Column sum memory: one write port and one registered read port.
// Depends on iig_pkg for its depth and word width.
module iig_col_ram (
  input  logic                            clk,
  input  logic                            wr_en,
  input  logic [iig_pkg::COL_W-1:0]       wr_addr,
  input  logic [iig_pkg::CSUM_W-1:0]      wr_data,
  input  logic                            rd_en,
  input  logic [iig_pkg::COL_W-1:0]       rd_addr,
  output logic [iig_pkg::CSUM_W-1:0]      rd_data
);

  logic [iig_pkg::CSUM_W-1:0] mem [iig_pkg::MAX_WIDTH];
  logic [iig_pkg::CSUM_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/iig_scan.sv -----
// Raster scan stage: tracks the column and row of the next pixel, flags row
// and frame ends and forms the summed value. Depends on iig_pkg.
module iig_scan (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  logic [iig_pkg::PIX_W-1:0]   pixel,
  input  logic                        square,
  input  logic [iig_pkg::COL_W:0]     width_eff,
  input  logic [iig_pkg::ROW_W:0]     height_eff,
  output iig_pkg::item_t              item
);

  logic [iig_pkg::COL_W-1:0] col_r, col_nxt;
  logic [iig_pkg::ROW_W-1:0] row_r, row_nxt;
  logic                      last_col;
  logic                      last_row;

  assign last_col = ({1'b0, col_r} + 1'b1) >= width_eff;
  assign last_row = ({1'b0, row_r} + 1'b1) >= height_eff;

  always_comb begin
    item.col      = col_r;
    item.row_zero = (row_r == '0);
    item.last_col = last_col;
    item.last_row = last_row;
    item.value    = square ? (iig_pkg::VAL_W'(pixel) * iig_pkg::VAL_W'(pixel))
                           : iig_pkg::VAL_W'(pixel);
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (fire) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// ----- rtl/iig_accum.sv -----
// Accumulator stage: finishes the column read-modify-write, adds the new
// column sum along the row and holds the result register. Depends on iig_pkg.
module iig_accum (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             load,
  input  iig_pkg::item_t                   item_in,
  input  logic [iig_pkg::CSUM_W-1:0]       rd_data,
  output logic                             ready,
  output logic                             wr_en,
  output logic [iig_pkg::COL_W-1:0]        wr_addr,
  output logic [iig_pkg::CSUM_W-1:0]       wr_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [iig_pkg::SUM_W-1:0]        out_sum,
  output logic                             out_row_end,
  output logic                             out_frame_end
);

  iig_pkg::item_t              item_r;
  logic                        s1_v_r, s1_v_nxt;
  logic                        fwd_r;
  logic [iig_pkg::CSUM_W-1:0]  fwd_data_r;
  logic [iig_pkg::ACC_W-1:0]   acc_r;
  logic                        out_v_r, out_v_nxt;
  logic [iig_pkg::SUM_W-1:0]   out_sum_r;
  logic                        out_row_end_r;
  logic                        out_frame_end_r;

  logic                        s1_go;
  logic [iig_pkg::CSUM_W-1:0]  prev;
  logic [iig_pkg::CSUM_W-1:0]  csum_new;
  logic [iig_pkg::ACC_W-1:0]   acc_base;
  logic [iig_pkg::ACC_W-1:0]   acc_new;

  assign s1_go = s1_v_r && (!out_v_r || out_ready);
  assign ready = !s1_v_r || !out_v_r || out_ready;

  // The memory read for the next pixel happens on the same edge as this
  // write, so a pixel in the same column takes the new sum from fwd_data_r.
  always_comb begin
    if (item_r.row_zero) begin
      prev = '0;
    end else if (fwd_r) begin
      prev = fwd_data_r;
    end else begin
      prev = rd_data;
    end
    csum_new = prev + iig_pkg::CSUM_W'(item_r.value);
    acc_base = (item_r.col == '0) ? '0 : acc_r;
    acc_new  = acc_base + iig_pkg::ACC_W'(csum_new);
  end

  assign wr_en   = s1_go;
  assign wr_addr = item_r.col;
  assign wr_data = csum_new;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (load) begin
      s1_v_nxt = 1'b1;
    end else if (s1_go) begin
      s1_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (s1_go) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      fwd_r   <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      if (load) begin
        fwd_r <= s1_go && (item_r.col == item_in.col);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r     <= item_in;
      fwd_data_r <= csum_new;
    end
    if (s1_go) begin
      acc_r           <= acc_new;
      out_sum_r       <= acc_new[iig_pkg::SUM_W-1:0];
      out_row_end_r   <= item_r.last_col;
      out_frame_end_r <= item_r.last_col && item_r.last_row;
    end
  end

  assign out_valid     = out_v_r;
  assign out_sum       = out_sum_r;
  assign out_row_end   = out_row_end_r;
  assign out_frame_end = out_frame_end_r;

endmodule

// ----- rtl/iig_checker.sv -----
// Port-level checks for the integral image generator, bound to the top level.
// Depends on iig_pkg and integral_image_generator.
module iig_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tready,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [iig_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            out_tlast,
  input  logic [0:0]                      out_tuser
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  // The end of a frame is always also the end of a row.
  a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("frame end without row end");

  // The padding bits above the sum stay zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[iig_pkg::OUT_TDATA_W-1:iig_pkg::SUM_W] == '0))
    else $error("nonzero padding in out_tdata");

  // Reset empties the output and starts the memory clear.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("block not idle after reset");

endmodule

bind integral_image_generator iig_checker u_iig_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
